// File: sv/eerm_pkg.sv
// Shared types, constants and codes for the EEPROM record ring manager.
package eerm_pkg;

   // Device geometry and table layout
   localparam int PAGE_BYTES = 64;
   localparam int PAGE_BITS  = 6;
   localparam int MEM_BYTES  = 32768;
   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = 4;
   localparam logic [16:0] SEQ_BASE  = 17'h00040;
   localparam logic [16:0] ADDR_BASE = 17'h00060;
   localparam logic [16:0] DATA_BASE = 17'h00080;
   localparam logic [16:0] MEM_TOP   = 17'(MEM_BYTES);

   // Command codes
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_APPEND = 2'd2;
   localparam logic [1:0] CMD_LOCATE = 2'd3;

   // Result kinds
   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_ADDR  = 3'd1;
   localparam logic [2:0] KIND_SEQ   = 3'd2;
   localparam logic [2:0] KIND_READ  = 3'd3;
   localparam logic [2:0] KIND_DONE  = 3'd4;

   // Register indexes
   localparam logic [1:0] REG_BUS_DEVICE   = 2'd0;
   localparam logic [1:0] REG_RECORD_LIMIT = 2'd1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  entry_index;
      logic [15:0] sequence_word;
      logic [15:0] address_word;
      logic [15:0] record_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [6:0]  bus_device;
      logic [14:0] start_addr;
      logic [8:0]  length;
      logic [7:0]  chunk_offset;
      logic [15:0] word_value;
      logic        last;
      logic        error;
      logic [15:0] record_count;
      logic [3:0]  slot_index;
   } rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_RD_SEQ0,
      OP_CHECK,
      OP_CLR_SEQ,
      OP_CLR_ADDR,
      OP_SCAN_RD,
      OP_SCAN_CMP,
      OP_LAT_RD,
      OP_LAT_SET,
      OP_CHUNK,
      OP_TAIL,
      OP_ADDR_RD,
      OP_ADDR_EMIT,
      OP_SEQ_RD,
      OP_SEQ_EMIT,
      OP_LOC_ERR,
      OP_READ1,
      OP_READ2,
      OP_DONE
   } dp_op_type;

   typedef struct packed {
      logic       out_free;
      logic [1:0] cmd;
      logic       err;
      logic       uninit;
      logic       idx_last;
      logic       chunk_last;
      logic       loc_bad;
      logic       split;
   } dp_status_type;

endpackage

// File: sv/eerm_ram.sv
// Generic single write port, single read port RAM with registered read.
module eerm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/eerm_dp.sv
// Datapath: configuration, ring state, both tables and the result register.
module eerm_dp
   import eerm_pkg::*;
#(
   parameter int RECORD_BYTES = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_op_type     op,
   input  req_type       req_data,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic          rsp_stall,
   output dp_status_type status,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   localparam logic [8:0]  REC  = 9'(RECORD_BYTES);
   localparam logic [16:0] RECX = 17'(RECORD_BYTES);
   localparam logic [8:0]  PAGE = 9'(PAGE_BYTES);

   logic [6:0]  bus_dev_ff, bus_dev_in;
   logic [15:0] limit_ff, limit_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic        err_ff, err_in;
   logic [15:0] latest_ff, latest_in;
   logic [14:0] next_ff, next_in;
   logic [3:0]  slot_ff, slot_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] best_ff, best_in;
   logic [3:0]  bslot_ff, bslot_in;
   logic [3:0]  idx_ff, idx_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  off_ff, off_in;
   logic        fresh_ff, fresh_in;
   logic        wrap_ff, wrap_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        seq_we, addr_we;
   logic [3:0]  seq_waddr, addr_waddr, seq_raddr, addr_raddr;
   logic [15:0] seq_wdata, addr_wdata, seq_rdata, addr_rdata;

   logic        out_free;
   logic [8:0]  room, size;
   logic [16:0] next17, step_sum, tail, lat_sum, lat_wrap, lat17, loc_end, first17;
   logic [14:0] step_addr, start_next;
   logic [16:0] seq_plus;
   logic [14:0] tbl_seq_addr, tbl_addr_addr;
   logic [15:0] seq_word;
   logic        loc_bad, split;

   eerm_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_seq_ram (
      .clock(clock), .we(seq_we), .waddr(seq_waddr), .wdata(seq_wdata),
      .raddr(seq_raddr), .rdata(seq_rdata)
   );

   eerm_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_addr_ram (
      .clock(clock), .we(addr_we), .waddr(addr_waddr), .wdata(addr_wdata),
      .raddr(addr_raddr), .rdata(addr_rdata)
   );

   function automatic rsp_type mk_rsp(input logic [2:0] kind, input logic [6:0] dev,
                                      input logic [14:0] addr, input logic [8:0] len,
                                      input logic [7:0] off, input logic [15:0] word,
                                      input logic err, input logic [15:0] cnt,
                                      input logic [3:0] slot);
      rsp_type r;
      r.kind         = kind;
      r.bus_device   = dev;
      r.start_addr   = addr;
      r.length       = len;
      r.chunk_offset = off;
      r.word_value   = word;
      r.last         = (kind == KIND_DONE);
      r.error        = err;
      r.record_count = cnt;
      r.slot_index   = slot;
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Chunk size: rest of the record, capped at the page room (a whole page on a fresh log)
   assign room      = fresh_ff ? PAGE : PAGE - {3'b0, next_ff[PAGE_BITS-1:0]};
   assign size      = (rem_ff <= room) ? rem_ff : room;
   assign next17    = {2'b0, next_ff};
   assign step_sum  = next17 + {8'b0, size};
   assign step_addr = (step_sum[14:0] < DATA_BASE[14:0]) ? DATA_BASE[14:0]
                                                         : step_sum[14:0];

   // Start of the record just written, measured back across the wrap
   assign tail = (next17 >= DATA_BASE + RECX) ? next17 - RECX
                                              : MEM_TOP - (RECX - (next17 - DATA_BASE));

   // Next address derived from the latest stored record
   assign lat_sum  = {1'b0, addr_rdata} + RECX;
   assign lat_wrap = (lat_sum >= MEM_TOP) ? lat_sum - MEM_TOP + DATA_BASE : lat_sum;
   assign start_next = (best_ff == 16'd0 || lat_wrap >= MEM_TOP || lat_wrap < DATA_BASE)
                       ? DATA_BASE[14:0] : lat_wrap[14:0];

   // Locate checks
   assign lat17   = {1'b0, latest_ff};
   assign loc_end = lat17 + RECX;
   assign loc_bad = (lat17 < DATA_BASE) || (lat17 >= MEM_TOP);
   assign split   = loc_end > MEM_TOP;
   assign first17 = MEM_TOP - lat17;

   assign seq_plus      = {1'b0, seq_ff} + 17'd1;
   assign tbl_seq_addr  = SEQ_BASE[14:0] + {10'b0, idx_ff, 1'b0};
   assign tbl_addr_addr = ADDR_BASE[14:0] + {10'b0, idx_ff, 1'b0};
   assign seq_word      = (idx_ff == slot_ff) ? seq_ff : (wrap_ff ? 16'd0 : seq_rdata);

   assign seq_raddr  = (op == OP_RD_SEQ0) ? 4'd0 : idx_ff;
   assign addr_raddr = (op == OP_LAT_RD) ? bslot_ff : idx_ff;

   // Next state of registers and table writes
   always_comb begin
      bus_dev_in   = bus_dev_ff;
      limit_in     = limit_ff;
      cmd_in       = cmd_ff;
      err_in       = err_ff;
      latest_in    = latest_ff;
      next_in      = next_ff;
      slot_in      = slot_ff;
      seq_in       = seq_ff;
      best_in      = best_ff;
      bslot_in     = bslot_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      off_in       = off_ff;
      fresh_in     = fresh_ff;
      wrap_in      = wrap_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      seq_we       = 1'b0;
      addr_we      = 1'b0;
      seq_waddr    = idx_ff;
      addr_waddr   = idx_ff;
      seq_wdata    = 16'd0;
      addr_wdata   = 16'(DATA_BASE);

      if (csr_valid) begin
         if (csr_index == REG_BUS_DEVICE) begin
            bus_dev_in = csr_wdata[6:0];
         end else if (csr_index == REG_RECORD_LIMIT) begin
            limit_in = csr_wdata;
         end
      end

      unique case (op)
         OP_ACCEPT: begin
            cmd_in = req_data.cmd;
            err_in = (req_data.cmd == CMD_APPEND || req_data.cmd == CMD_LOCATE)
                     && (req_data.record_length != 16'(RECORD_BYTES));
            if (req_data.cmd == CMD_LOAD) begin
               seq_we     = 1'b1;
               addr_we    = 1'b1;
               seq_waddr  = req_data.entry_index;
               addr_waddr = req_data.entry_index;
               seq_wdata  = req_data.sequence_word;
               addr_wdata = req_data.address_word;
            end
            if (req_data.cmd == CMD_APPEND &&
                req_data.record_length == 16'(RECORD_BYTES)) begin
               rem_in   = REC;
               off_in   = 9'd0;
               fresh_in = (seq_ff == 16'd0);
               slot_in  = slot_ff + 4'd1;
               wrap_in  = seq_plus > {1'b0, limit_ff};
               seq_in   = (seq_plus > {1'b0, limit_ff}) ? 16'd1 : seq_plus[15:0];
            end
         end
         OP_CHECK: begin
            idx_in   = 4'd0;
            best_in  = 16'd0;
            bslot_in = 4'd0;
            if (seq_rdata > limit_ff) begin
               seq_in    = 16'd0;
               slot_in   = 4'd0;
               latest_in = 16'(DATA_BASE);
               next_in   = DATA_BASE[14:0];
            end
         end
         OP_CLR_SEQ: begin
            seq_we       = 1'b1;
            addr_we      = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_SEQ, bus_dev_ff, tbl_seq_addr, 9'd2, 8'd0, 16'd0,
                            1'b0, seq_ff, slot_ff);
            idx_in = idx_ff + 4'd1;
         end
         OP_CLR_ADDR: begin
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_ADDR, bus_dev_ff, tbl_addr_addr, 9'd2, 8'd0,
                            16'(DATA_BASE), 1'b0, seq_ff, slot_ff);
            idx_in = idx_ff + 4'd1;
         end
         OP_SCAN_CMP: begin
            if (seq_rdata > best_ff) begin
               best_in  = seq_rdata;
               bslot_in = idx_ff;
            end
            idx_in = idx_ff + 4'd1;
         end
         OP_LAT_SET: begin
            latest_in = addr_rdata;
            seq_in    = best_ff;
            slot_in   = bslot_ff;
            next_in   = start_next;
         end
         OP_CHUNK: begin
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_WRITE, bus_dev_ff, next_ff, size, off_ff[7:0], 16'd0,
                            1'b0, seq_ff, slot_ff);
            next_in = step_addr;
            rem_in  = rem_ff - size;
            off_in  = off_ff + size;
         end
         OP_TAIL: begin
            latest_in  = tail[15:0];
            addr_we    = 1'b1;
            addr_waddr = slot_ff;
            addr_wdata = tail[15:0];
            idx_in     = 4'd0;
         end
         OP_ADDR_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_ADDR, bus_dev_ff, tbl_addr_addr, 9'd2, 8'd0, addr_rdata,
                            1'b0, seq_ff, slot_ff);
            idx_in = idx_ff + 4'd1;
         end
         OP_SEQ_EMIT: begin
            seq_we       = 1'b1;
            seq_wdata    = seq_word;
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_SEQ, bus_dev_ff, tbl_seq_addr, 9'd2, 8'd0, seq_word,
                            1'b0, seq_ff, slot_ff);
            idx_in = idx_ff + 4'd1;
         end
         OP_LOC_ERR: begin
            err_in = 1'b1;
         end
         OP_READ1: begin
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_READ, bus_dev_ff, latest_ff[14:0],
                            split ? first17[8:0] : REC, 8'd0, 16'd0, 1'b0, seq_ff, slot_ff);
         end
         OP_READ2: begin
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_READ, bus_dev_ff, DATA_BASE[14:0], REC - first17[8:0],
                            first17[7:0], 16'd0, 1'b0, seq_ff, slot_ff);
         end
         OP_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in = mk_rsp(KIND_DONE, bus_dev_ff, 15'd0, 9'd0, 8'd0, 16'd0, err_ff,
                            seq_ff, slot_ff);
         end
         default: begin
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_dev_ff   <= 7'd80;
         limit_ff     <= 16'd200;
         latest_ff    <= 16'd0;
         next_ff      <= DATA_BASE[14:0];
         slot_ff      <= 4'd0;
         seq_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bus_dev_ff   <= bus_dev_in;
         limit_ff     <= limit_in;
         latest_ff    <= latest_in;
         next_ff      <= next_in;
         slot_ff      <= slot_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of one item
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      err_ff   <= err_in;
      best_ff  <= best_in;
      bslot_ff <= bslot_in;
      idx_ff   <= idx_in;
      rem_ff   <= rem_in;
      off_ff   <= off_in;
      fresh_ff <= fresh_in;
      wrap_ff  <= wrap_in;
      rsp_ff   <= rsp_in;
   end

   assign status.out_free   = out_free;
   assign status.cmd        = cmd_ff;
   assign status.err        = err_ff;
   assign status.uninit     = seq_rdata > limit_ff;
   assign status.idx_last   = (idx_ff == 4'(SLOTS - 1));
   assign status.chunk_last = (rem_ff == size);
   assign status.loc_bad    = loc_bad;
   assign status.split      = split;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_last_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last == (rsp_ff.kind == KIND_DONE)))
      else $error("last flag set on a word other than done");

   a_error_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.error) |-> (rsp_ff.kind == KIND_DONE))
      else $error("error flag on a transfer word");

   a_next_in_region: assert property (@(posedge clock) disable iff (reset)
      (op == OP_CHUNK) |=> ({2'b0, next_ff} >= DATA_BASE))
      else $error("next address left the data region");

endmodule

// File: sv/eerm_ctrl.sv
// Controller: sequences the datapath through load, start, append and locate.
module eerm_ctrl
   import eerm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output logic          req_stall,
   output dp_op_type     op
);

   typedef enum logic [18:0] {
      S_IDLE      = 19'h00001,
      S_DISPATCH  = 19'h00002,
      S_START_RD  = 19'h00004,
      S_START_CHK = 19'h00008,
      S_CLR_SEQ   = 19'h00010,
      S_CLR_ADDR  = 19'h00020,
      S_SCAN_RD   = 19'h00040,
      S_SCAN_CMP  = 19'h00080,
      S_LAT_RD    = 19'h00100,
      S_LAT_SET   = 19'h00200,
      S_CHUNK     = 19'h00400,
      S_TAIL      = 19'h00800,
      S_ADDR_RD   = 19'h01000,
      S_ADDR_EM   = 19'h02000,
      S_SEQ_RD    = 19'h04000,
      S_SEQ_EM    = 19'h08000,
      S_LOCATE    = 19'h10000,
      S_READ2     = 19'h20000,
      S_DONE      = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state and datapath operation
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op       = OP_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.err)                state_in = S_DONE;
            else if (status.cmd == CMD_START)       state_in = S_START_RD;
            else if (status.cmd == CMD_APPEND)      state_in = S_CHUNK;
            else if (status.cmd == CMD_LOCATE)      state_in = S_LOCATE;
            else                                    state_in = S_DONE;
         end
         S_START_RD: begin
            op       = OP_RD_SEQ0;
            state_in = S_START_CHK;
         end
         S_START_CHK: begin
            op       = OP_CHECK;
            state_in = status.uninit ? S_CLR_SEQ : S_SCAN_RD;
         end
         S_CLR_SEQ: begin
            if (status.out_free) begin
               op = OP_CLR_SEQ;
               if (status.idx_last) state_in = S_CLR_ADDR;
            end
         end
         S_CLR_ADDR: begin
            if (status.out_free) begin
               op = OP_CLR_ADDR;
               if (status.idx_last) state_in = S_DONE;
            end
         end
         S_SCAN_RD: begin
            op       = OP_SCAN_RD;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            op       = OP_SCAN_CMP;
            state_in = status.idx_last ? S_LAT_RD : S_SCAN_RD;
         end
         S_LAT_RD: begin
            op       = OP_LAT_RD;
            state_in = S_LAT_SET;
         end
         S_LAT_SET: begin
            op       = OP_LAT_SET;
            state_in = S_DONE;
         end
         S_CHUNK: begin
            if (status.out_free) begin
               op = OP_CHUNK;
               if (status.chunk_last) state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            op       = OP_TAIL;
            state_in = S_ADDR_RD;
         end
         S_ADDR_RD: begin
            op       = OP_ADDR_RD;
            state_in = S_ADDR_EM;
         end
         S_ADDR_EM: begin
            if (status.out_free) begin
               op       = OP_ADDR_EMIT;
               state_in = status.idx_last ? S_SEQ_RD : S_ADDR_RD;
            end
         end
         S_SEQ_RD: begin
            op       = OP_SEQ_RD;
            state_in = S_SEQ_EM;
         end
         S_SEQ_EM: begin
            if (status.out_free) begin
               op       = OP_SEQ_EMIT;
               state_in = status.idx_last ? S_DONE : S_SEQ_RD;
            end
         end
         S_LOCATE: begin
            priority if (status.loc_bad) begin
               op       = OP_LOC_ERR;
               state_in = S_DONE;
            end else if (status.out_free) begin
               op       = OP_READ1;
               state_in = status.split ? S_READ2 : S_DONE;
            end
         end
         S_READ2: begin
            if (status.out_free) begin
               op       = OP_READ2;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               op       = OP_DONE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DISPATCH))
      else $error("accepted word did not start a command");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state lost its one-hot code");

endmodule

// File: sv/eeprom_record_ring_manager_core.sv
// Top level of the EEPROM record ring manager.
//
// Request channel (req_valid / req_stall / req_data) takes one command word at a
// time: load a table slot, start (validate tables and find the latest record),
// append a record, or locate the latest record. Each command yields a run of
// transfer descriptor words on the response channel (rsp_valid / rsp_stall /
// rsp_data), closed by a done word with last set. csr_* writes the bus device
// address (index 0) and the record limit (index 1); csr_ready is always high.
// The controller handles one command at a time: req_stall stays high from
// acceptance until the done word has been loaded into the output register.
// Start reads and compares each sequence slot in turn, or on uninitialised tables
// emits one word per slot of each table instead. Append emits its record in one
// write chunk or two, then reads each table word from the table RAMs and emits it.
// Locate emits one read or two, or just an error if the latest address is outside
// the data region; a refused record length yields only the done word. A stalled
// response word holds in the output register and the controller waits; no word is
// lost. Reset restores the register defaults and the ring state; table contents stay
// undefined until loaded.
module eeprom_record_ring_manager_core
   import eerm_pkg::*;
#(
   parameter int RECORD_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dp_op_type     op;
   dp_status_type status;

   assign csr_ready = 1'b1;

   eerm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .status   (status),
      .req_stall(req_stall),
      .op       (op)
   );

   eerm_dp #(.RECORD_BYTES(RECORD_BYTES)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_stall(rsp_stall),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

// File: dv/eeprom_record_ring_manager_core_test.sv
// Self-checking testbench for the EEPROM record ring manager core.
module eeprom_record_ring_manager_core_test
   import eerm_pkg::*;
();

   localparam int REC_BYTES = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   eeprom_record_ring_manager_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Pending commands, expected descriptors and run flags
   req_type     command_q[$];
   rsp_type     descriptor_q[$];
   int          mismatches = 0;
   bit          calm = 1'b0;
   bit          want_hold = 1'b0;
   int          hold_left = 0;

   // Shadow copy of the ring state and registers
   int unsigned dev_addr, rec_limit;
   int unsigned seq_tab[SLOTS];
   int unsigned addr_tab[SLOTS];
   int unsigned latest_addr, next_addr, cur_slot, cur_seq;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic rsp_type make_word(logic [2:0] kind, int unsigned addr,
                                         int unsigned len, int unsigned off,
                                         int unsigned word, bit err);
      rsp_type w;
      w = '0;
      w.kind = kind;
      w.bus_device = dev_addr[6:0];
      w.start_addr = addr[14:0];
      w.length = len[8:0];
      w.chunk_offset = off[7:0];
      w.word_value = word[15:0];
      w.last = (kind == KIND_DONE);
      w.error = err;
      return w;
   endfunction

   function automatic int unsigned page_room();
      if (cur_seq == 0) return PAGE_BYTES;
      return PAGE_BYTES - (next_addr % PAGE_BYTES);
   endfunction

   // Work out the descriptors one command causes and advance the shadow state
   task automatic model_command(req_type r);
      rsp_type     words[$];
      int unsigned best, slot, nx, rem, off, room, sz, sq, first;
      bit          err;
      err = 1'b0;
      if (r.cmd == CMD_LOAD) begin
         seq_tab[r.entry_index] = r.sequence_word;
         addr_tab[r.entry_index] = r.address_word;
      end else if (r.cmd == CMD_START) begin
         best = 0;
         slot = 0;
         // clear tables that were never set up
         if (seq_tab[0] > rec_limit) begin
            for (int i = 0; i < SLOTS; i++) begin
               seq_tab[i] = 0;
               addr_tab[i] = DATA_BASE;
            end
            for (int i = 0; i < SLOTS; i++)
               words.push_back(make_word(KIND_SEQ, SEQ_BASE + 2*i, 2, 0, 0, 0));
            for (int i = 0; i < SLOTS; i++)
               words.push_back(make_word(KIND_ADDR, ADDR_BASE + 2*i, 2, 0,
                                         DATA_BASE, 0));
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (seq_tab[i] > best) begin
               best = seq_tab[i];
               slot = i;
            end
         end
         cur_slot = slot;
         cur_seq = best;
         latest_addr = addr_tab[slot];
         if (best == 0) begin
            nx = DATA_BASE;
         end else begin
            nx = latest_addr + REC_BYTES;
            if (nx >= MEM_BYTES) nx = nx - MEM_BYTES + DATA_BASE;
            if (nx >= MEM_BYTES || nx < DATA_BASE) nx = DATA_BASE;
         end
         next_addr = nx;
      end else if (r.record_length != REC_BYTES) begin
         err = 1'b1;
      end else if (r.cmd == CMD_APPEND) begin
         rem = REC_BYTES;
         off = 0;
         room = page_room();
         sz = (REC_BYTES <= room) ? REC_BYTES : room;
         // split the record at page edges, wrapping into the data region
         while (rem > 0) begin
            words.push_back(make_word(KIND_WRITE, next_addr, sz, off, 0, 0));
            rem -= sz;
            off += sz;
            next_addr = (next_addr + sz) % MEM_BYTES;
            if (next_addr < DATA_BASE) next_addr = DATA_BASE;
            room = page_room();
            sz = (room >= rem) ? rem : room;
         end
         if (next_addr >= DATA_BASE + REC_BYTES)
            latest_addr = next_addr - REC_BYTES;
         else
            latest_addr = MEM_BYTES - (REC_BYTES - (next_addr - DATA_BASE));
         cur_slot = (cur_slot + 1) % SLOTS;
         addr_tab[cur_slot] = latest_addr & 16'hFFFF;
         sq = cur_seq + 1;
         if (sq > rec_limit) begin
            sq = 1;
            for (int i = 0; i < SLOTS; i++) seq_tab[i] = 0;
         end
         cur_seq = sq & 16'hFFFF;
         seq_tab[cur_slot] = cur_seq;
         for (int i = 0; i < SLOTS; i++)
            words.push_back(make_word(KIND_ADDR, ADDR_BASE + 2*i, 2, 0, addr_tab[i], 0));
         for (int i = 0; i < SLOTS; i++)
            words.push_back(make_word(KIND_SEQ, SEQ_BASE + 2*i, 2, 0, seq_tab[i], 0));
      end else begin
         // locate: one read, or two across the top of memory
         if (latest_addr < DATA_BASE || latest_addr >= MEM_BYTES) begin
            err = 1'b1;
         end else if (latest_addr + REC_BYTES <= MEM_BYTES) begin
            words.push_back(make_word(KIND_READ, latest_addr, REC_BYTES, 0, 0, 0));
         end else begin
            first = MEM_BYTES - latest_addr;
            words.push_back(make_word(KIND_READ, latest_addr, first, 0, 0, 0));
            words.push_back(make_word(KIND_READ, DATA_BASE, REC_BYTES - first,
                                      first, 0, 0));
         end
      end
      words.push_back(make_word(KIND_DONE, 0, 0, 0, 0, err));
      foreach (words[k]) begin
         words[k].record_count = cur_seq[15:0];
         words[k].slot_index = cur_slot[3:0];
         descriptor_q.push_back(words[k]);
      end
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // Driver: advance to the next command once the current word is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) model_command(req_data);
         if (command_q.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
            req_valid <= 1'b1;
            req_data <= command_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (want_hold && hold_left == 0) begin
         want_hold = 1'b0;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= (hold_left > 0);
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 37);
      end
   end

   // Monitor: compare each taken word with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (descriptor_q.size() == 0) begin
            report_mismatch("unexpected word, kind", rsp_data.kind, 0);
         end else begin
            want = descriptor_q.pop_front();
            if (rsp_data.kind != want.kind)
               report_mismatch("kind", rsp_data.kind, want.kind);
            if (rsp_data.bus_device != want.bus_device)
               report_mismatch("bus_device", rsp_data.bus_device, want.bus_device);
            if (rsp_data.start_addr != want.start_addr)
               report_mismatch("start_addr", rsp_data.start_addr, want.start_addr);
            if (rsp_data.length != want.length)
               report_mismatch("length", rsp_data.length, want.length);
            if (rsp_data.chunk_offset != want.chunk_offset)
               report_mismatch("chunk_offset", rsp_data.chunk_offset, want.chunk_offset);
            if (rsp_data.word_value != want.word_value)
               report_mismatch("word_value", rsp_data.word_value, want.word_value);
            if (rsp_data.last != want.last)
               report_mismatch("last", rsp_data.last, want.last);
            if (rsp_data.error != want.error)
               report_mismatch("error", rsp_data.error, want.error);
            if (rsp_data.record_count != want.record_count)
               report_mismatch("record_count", rsp_data.record_count, want.record_count);
            if (rsp_data.slot_index != want.slot_index)
               report_mismatch("slot_index", rsp_data.slot_index, want.slot_index);
         end
      end
   end

   function automatic req_type make_cmd(logic [1:0] cmd, int unsigned idx,
                                        int unsigned sq, int unsigned ad,
                                        int unsigned len);
      req_type r;
      r.cmd = cmd;
      r.entry_index = idx[3:0];
      r.sequence_word = sq[15:0];
      r.address_word = ad[15:0];
      r.record_length = len[15:0];
      return r;
   endfunction

   // Mostly well-formed appends and locates, with loads, starts and noise
   function automatic req_type random_cmd();
      req_type     r;
      int unsigned pick, sq, ad, len;
      pick = $urandom_range(99);
      r = '0;
      r.entry_index = 4'($urandom_range(15));
      r.record_length = 16'(REC_BYTES);
      case ($urandom_range(9))
         0, 1:    sq = $urandom_range(rec_limit < 40 ? rec_limit : 40);
         2:       sq = $urandom_range(16'hFFFF);
         default: sq = $urandom_range(rec_limit);
      endcase
      case ($urandom_range(9))
         0, 1:    ad = $urandom_range(MEM_BYTES - 1, MEM_BYTES - 40);
         2:       ad = $urandom_range(16'hFFFF);
         3:       ad = $urandom_range(DATA_BASE - 1);
         default: ad = $urandom_range(MEM_BYTES - 1, DATA_BASE);
      endcase
      len = ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF) : REC_BYTES + 1;
      if (pick < 50)      r.cmd = CMD_APPEND;
      else if (pick < 57) begin
         r.cmd = CMD_APPEND;
         r.record_length = len[15:0];
      end else if (pick < 70) begin
         r.cmd = CMD_LOCATE;
         if ($urandom_range(5) == 0) r.record_length = len[15:0];
      end else if (pick < 88) begin
         r.cmd = CMD_LOAD;
         r.sequence_word = sq[15:0];
         r.address_word = ad[15:0];
      end else begin
         r.cmd = CMD_START;
      end
      return r;
   endfunction

   task automatic write_reg(logic [1:0] idx, int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_BUS_DEVICE) dev_addr = value & 7'h7F;
      else rec_limit = value & 16'hFFFF;
      csr_valid <= 1'b0;
   endtask

   // Hold until every command is taken and every word has come back
   task automatic drain();
      do @(negedge clock);
      while (command_q.size() > 0 || req_valid || descriptor_q.size() > 0);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      dev_addr = 80;
      rec_limit = 200;
      latest_addr = 0;
      next_addr = DATA_BASE;
      cur_slot = 0;
      cur_seq = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: fill every slot, then exercise each command and edge
      for (int i = 0; i < SLOTS; i++)
         command_q.push_back(make_cmd(CMD_LOAD, i, i,
                                      DATA_BASE + REC_BYTES * i, 0));
      command_q.push_back(make_cmd(CMD_LOAD, 3, 16'hFFFF, MEM_BYTES - 24, 0));
      command_q.push_back(make_cmd(CMD_LOCATE, 0, 0, 0, REC_BYTES));
      command_q.push_back(make_cmd(CMD_START, 0, 0, 0, 0));
      command_q.push_back(make_cmd(CMD_APPEND, 0, 0, 0, REC_BYTES));
      command_q.push_back(make_cmd(CMD_LOCATE, 0, 0, 0, REC_BYTES));
      command_q.push_back(make_cmd(CMD_APPEND, 0, 0, 0, 0));
      command_q.push_back(make_cmd(CMD_LOCATE, 0, 0, 0, 16'hFFFF));
      command_q.push_back(make_cmd(CMD_LOAD, 0, 16'hFFFF, 16'hFFFF, 0));
      command_q.push_back(make_cmd(CMD_START, 0, 0, 0, 0));
      drain();

      // Smallest limit, device address zero
      write_reg(REG_BUS_DEVICE, 0);
      write_reg(REG_RECORD_LIMIT, 1);
      repeat (112) command_q.push_back(random_cmd());
      drain();

      // Largest limit and device address, no idling on either side
      write_reg(REG_BUS_DEVICE, 127);
      write_reg(REG_RECORD_LIMIT, 16'hFFFF);
      @(negedge clock) calm = 1'b1;
      repeat (112) command_q.push_back(random_cmd());
      drain();
      @(negedge clock) calm = 1'b0;

      // Small random limit; the receiver holds off while commands queue up
      write_reg(REG_BUS_DEVICE, $urandom_range(127));
      write_reg(REG_RECORD_LIMIT, $urandom_range(30, 2));
      repeat (112) command_q.push_back(random_cmd());
      @(negedge clock) want_hold = 1'b1;
      drain();

      write_reg(REG_BUS_DEVICE, $urandom_range(127));
      write_reg(REG_RECORD_LIMIT, $urandom_range(16'hFFFF, 1));
      repeat (112) command_q.push_back(random_cmd());
      drain();

      if (mismatches == 0 && descriptor_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
